// ===== design/ccfi_pkg.sv =====
// ccfi_pkg: shared types, codes, widths and the closure offset table of the face indexer
// depends on nothing; every design file refers to it by scoped names
package ccfi_pkg;

    localparam int MAX_SIDE       = 256;
    localparam int SIZE_W         = 9;
    localparam int GRID_W         = 10;
    localparam int IDX_W          = 28;
    localparam int G01_W          = 2 * GRID_W;
    localparam int S01_W          = 2 * SIZE_W - 1;
    localparam int CCOUNT_W       = G01_W + GRID_W;
    localparam int VCOUNT_W       = S01_W + SIZE_W;
    localparam int T_W            = 2 * GRID_W + 2;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = IDX_W / BITS_PER_STAGE;
    localparam int K_W            = 5;

    localparam logic [1:0] OP_FACES    = 2'd0;
    localparam logic [1:0] OP_CLOSURE  = 2'd1;
    localparam logic [1:0] OP_INCIDENT = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [1:0] KIND_VALID    = 2'd0;
    localparam logic [1:0] KIND_OUTSIDE  = 2'd1;
    localparam logic [1:0] KIND_NO_FACES = 2'd2;
    localparam logic [1:0] KIND_RANGE    = 2'd3;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    localparam logic [K_W-1:0] CLOSURE_COUNT = K_W'(27);

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] item_index;
    } ccfi_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_index;
        logic [1:0]       cell_dimension;
        logic [1:0]       kind;
        logic             is_last;
    } ccfi_out_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   s0;
        logic [SIZE_W-1:0]   s1;
        logic [SIZE_W-1:0]   s2;
        logic [GRID_W-1:0]   g0;
        logic [GRID_W-1:0]   g1;
        logic [GRID_W-1:0]   g2;
        logic [G01_W-1:0]    g01;
        logic [S01_W-1:0]    s01;
        logic [CCOUNT_W-1:0] ccount;
        logic [VCOUNT_W-1:0] vcount;
    } ccfi_geom_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  item;
        logic [GRID_W-1:0] c0;
    } ccfi_side_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] item;
        logic             err;
        logic [2:0]       odd;
        logic [1:0]       dim;
        logic [2:0]       out_first;
        logic [2:0]       out_second;
        logic [IDX_W-1:0] base;
    } ccfi_job_t;

    // closure offsets {ox, oy, oz}, two bits each
    function automatic logic [5:0] closure_off(input logic [K_W-1:0] k);
        logic [5:0] o;
        case (k)
            5'd0:    o = 6'b00_00_00;
            5'd1:    o = 6'b10_00_00;
            5'd2:    o = 6'b01_00_00;
            5'd3:    o = 6'b00_10_00;
            5'd4:    o = 6'b00_01_00;
            5'd5:    o = 6'b10_10_00;
            5'd6:    o = 6'b10_01_00;
            5'd7:    o = 6'b01_10_00;
            5'd8:    o = 6'b01_01_00;
            5'd9:    o = 6'b00_00_10;
            5'd10:   o = 6'b00_00_01;
            5'd11:   o = 6'b10_00_10;
            5'd12:   o = 6'b10_00_01;
            5'd13:   o = 6'b01_00_10;
            5'd14:   o = 6'b01_00_01;
            5'd15:   o = 6'b00_10_10;
            5'd16:   o = 6'b00_10_01;
            5'd17:   o = 6'b00_01_10;
            5'd18:   o = 6'b00_01_01;
            5'd19:   o = 6'b10_10_10;
            5'd20:   o = 6'b10_10_01;
            5'd21:   o = 6'b10_01_10;
            5'd22:   o = 6'b10_01_01;
            5'd23:   o = 6'b01_10_10;
            5'd24:   o = 6'b01_10_01;
            5'd25:   o = 6'b01_01_10;
            5'd26:   o = 6'b01_01_01;
            default: o = 6'b00_00_00;
        endcase
        return o;
    endfunction

endpackage

// ===== design/ccfi_config.sv =====
// ccfi_config: box size registers and the derived grid sizes and cell counts
// depends on ccfi_pkg
module ccfi_config (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic [1:0]               cfg_index,
    input  logic [ccfi_pkg::SIZE_W-1:0] cfg_data,
    output ccfi_pkg::ccfi_geom_t     geom
);

    logic [ccfi_pkg::SIZE_W-1:0]   size_x_reg, size_y_reg, size_z_reg;
    logic [ccfi_pkg::SIZE_W-1:0]   s0, s1, s2;
    logic [ccfi_pkg::GRID_W-1:0]   g0, g1, g2;
    logic [ccfi_pkg::G01_W-1:0]    g01_reg;
    logic [ccfi_pkg::S01_W-1:0]    s01_reg;
    logic [ccfi_pkg::CCOUNT_W-1:0] ccount_reg;
    logic [ccfi_pkg::VCOUNT_W-1:0] vcount_reg;

    function automatic logic [ccfi_pkg::SIZE_W-1:0] eff_size(
        input logic [ccfi_pkg::SIZE_W-1:0] r);
        logic [ccfi_pkg::SIZE_W-1:0] e;
        if (r == '0)
            e = ccfi_pkg::SIZE_W'(1);
        else if (r > ccfi_pkg::SIZE_W'(ccfi_pkg::MAX_SIDE))
            e = ccfi_pkg::SIZE_W'(ccfi_pkg::MAX_SIDE);
        else
            e = r;
        return e;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= ccfi_pkg::SIZE_W'(1);
            size_y_reg <= ccfi_pkg::SIZE_W'(1);
            size_z_reg <= ccfi_pkg::SIZE_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ccfi_pkg::REG_SIZE_X: size_x_reg <= cfg_data;
                ccfi_pkg::REG_SIZE_Y: size_y_reg <= cfg_data;
                ccfi_pkg::REG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s0 = eff_size(size_x_reg);
    assign s1 = eff_size(size_y_reg);
    assign s2 = eff_size(size_z_reg);
    assign g0 = {s0, 1'b1};
    assign g1 = {s1, 1'b1};
    assign g2 = {s2, 1'b1};

    // registered products: g01 and s01, then the cell and voxel counts from them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g01_reg    <= ccfi_pkg::G01_W'(9);
            s01_reg    <= ccfi_pkg::S01_W'(1);
            ccount_reg <= ccfi_pkg::CCOUNT_W'(27);
            vcount_reg <= ccfi_pkg::VCOUNT_W'(1);
        end
        else
        begin
            g01_reg    <= g0 * g1;
            s01_reg    <= ccfi_pkg::S01_W'(s0 * s1);
            ccount_reg <= g01_reg * g2;
            vcount_reg <= s01_reg * s2;
        end
    end

    assign geom = '{s0: s0, s1: s1, s2: s2, g0: g0, g1: g1, g2: g2, g01: g01_reg,
                    s01: s01_reg, ccount: ccount_reg, vcount: vcount_reg};

endmodule

// ===== design/ccfi_divider.sv =====
// ccfi_divider: pipelined restoring divider, two quotient bits per stage, sideband carried along
// depends on ccfi_pkg
module ccfi_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ccfi_pkg::IDX_W-1:0]  dividend,
    input  logic [ccfi_pkg::GRID_W-1:0] divisor,
    input  ccfi_pkg::ccfi_side_t        in_side,
    output logic                        out_valid,
    output logic [ccfi_pkg::IDX_W-1:0]  quotient,
    output logic [ccfi_pkg::GRID_W-1:0] remainder,
    output ccfi_pkg::ccfi_side_t        out_side
);

    localparam int N = ccfi_pkg::DIV_STAGES;
    localparam int W = ccfi_pkg::IDX_W;
    localparam int R = ccfi_pkg::GRID_W;

    logic [N-1:0]         valid_reg;
    logic [R-1:0]         rem_reg  [N];
    logic [W-1:0]         work_reg [N];
    logic [R-1:0]         dvs_reg  [N];
    ccfi_pkg::ccfi_side_t side_reg [N];

    function automatic logic [R+W-1:0] div_steps(input logic [R-1:0] rem,
                                                 input logic [W-1:0] work,
                                                 input logic [R-1:0] d);
        logic [R-1:0] r;
        logic [W-1:0] w;
        logic [R:0]   trial;
        r = rem;
        w = work;
        for (int b = 0; b < ccfi_pkg::BITS_PER_STAGE; b++)
        begin
            trial = {r, w[W-1]};
            w = {w[W-2:0], 1'b0};
            if (trial >= {1'b0, d})
            begin
                trial = trial - {1'b0, d};
                w[0] = 1'b1;
            end
            r = trial[R-1:0];
        end
        return {r, w};
    endfunction

    for (genvar j = 0; j < N; j++)
    begin : g_stage
        logic                 vin;
        logic [R-1:0]         rin, din;
        logic [W-1:0]         win;
        ccfi_pkg::ccfi_side_t sin;
        logic [R-1:0]         rem_next;
        logic [W-1:0]         work_next;

        if (j == 0)
        begin : g_first
            assign vin = in_valid;
            assign rin = '0;
            assign win = dividend;
            assign din = divisor;
            assign sin = in_side;
        end
        else
        begin : g_rest
            assign vin = valid_reg[j-1];
            assign rin = rem_reg[j-1];
            assign win = work_reg[j-1];
            assign din = dvs_reg[j-1];
            assign sin = side_reg[j-1];
        end

        assign {rem_next, work_next} = div_steps(rin, win, din);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (en)
                valid_reg[j] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                work_reg[j] <= work_next;
                dvs_reg[j]  <= din;
                side_reg[j] <= sin;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quotient  = work_reg[N-1];
    assign remainder = rem_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ===== design/ccfi_coord.sv =====
// ccfi_coord: range check, axis flags and the two-stage base index multiply
// depends on ccfi_pkg
module ccfi_coord (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ccfi_pkg::IDX_W-1:0]  q2,
    input  logic [ccfi_pkg::GRID_W-1:0] r2,
    input  ccfi_pkg::ccfi_side_t        side,
    input  ccfi_pkg::ccfi_geom_t        geom,
    output logic                        job_valid,
    output ccfi_pkg::ccfi_job_t         job
);

    localparam int GW = ccfi_pkg::GRID_W;
    localparam int SW = ccfi_pkg::SIZE_W;

    logic                       d_valid_reg;
    logic [1:0]                 d_op_reg;
    logic [ccfi_pkg::IDX_W-1:0] d_item_reg;
    logic                       d_err_reg;
    logic [GW-1:0]              d_c_reg [3];
    logic [ccfi_pkg::T_W-1:0]   d_t_reg;

    logic                       err_next;
    logic [GW-1:0]              c2;
    logic [GW:0]                a1, a2;
    logic [GW-1:0]              m1;
    logic [ccfi_pkg::T_W-1:0]   t_next;

    logic                       p_valid_reg;
    ccfi_pkg::ccfi_job_t        p_job_reg;
    ccfi_pkg::ccfi_job_t        job_next;
    logic [GW:0]                a0;
    logic [GW-1:0]              m0;
    logic [SW-1:0]              half [3];
    logic [SW-1:0]              half_m1 [3];
    logic [SW-1:0]              sz [3];

    assign c2 = q2[GW-1:0];

    always_comb
    begin
        case (side.op)
            ccfi_pkg::OP_CLOSURE:
                err_next = {{(ccfi_pkg::IDX_W + 2 - ccfi_pkg::VCOUNT_W){1'b0}}, geom.vcount}
                           <= {2'b00, side.item};
            ccfi_pkg::OP_FACES, ccfi_pkg::OP_INCIDENT:
                err_next = geom.ccount <= {2'b00, side.item};
            default:
                err_next = 1'b1;
        endcase
        // the closure multiplier for y uses the grid width, not the voxel size
        if (side.op == ccfi_pkg::OP_CLOSURE)
        begin
            a1 = {r2, 1'b0};
            a2 = {c2, 1'b0};
            m1 = geom.g1;
        end
        else
        begin
            a1 = {2'b00, r2[GW-1:1]};
            a2 = {2'b00, c2[GW-1:1]};
            m1 = {1'b0, geom.s1};
        end
        t_next = ccfi_pkg::T_W'(a1) + ccfi_pkg::T_W'(m1) * ccfi_pkg::T_W'(a2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_op_reg   <= side.op;
            d_item_reg <= side.item;
            d_err_reg  <= err_next;
            d_c_reg[0] <= side.c0;
            d_c_reg[1] <= r2;
            d_c_reg[2] <= c2;
            d_t_reg    <= t_next;
        end
    end

    assign sz[0] = geom.s0;
    assign sz[1] = geom.s1;
    assign sz[2] = geom.s2;

    always_comb
    begin
        if (d_op_reg == ccfi_pkg::OP_CLOSURE)
        begin
            a0 = {d_c_reg[0], 1'b0};
            m0 = geom.g0;
        end
        else
        begin
            a0 = {2'b00, d_c_reg[0][GW-1:1]};
            m0 = {1'b0, geom.s0};
        end
        job_next.op   = d_op_reg;
        job_next.item = d_item_reg;
        job_next.err  = d_err_reg;
        job_next.base = ccfi_pkg::IDX_W'(a0)
                        + ccfi_pkg::IDX_W'(m0) * ccfi_pkg::IDX_W'(d_t_reg);
        for (int i = 0; i < 3; i++)
        begin
            half[i]    = d_c_reg[i][GW-1:1];
            half_m1[i] = half[i] - SW'(1);
            job_next.odd[i]        = d_c_reg[i][0];
            job_next.out_first[i]  = half[i] >= sz[i];
            job_next.out_second[i] = (d_c_reg[i] == '0) || (half_m1[i] >= sz[i]);
        end
        job_next.dim = 2'({1'b0, d_c_reg[0][0]} + {1'b0, d_c_reg[1][0]}
                          + {1'b0, d_c_reg[2][0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p_job_reg <= job_next;
    end

    assign job_valid = p_valid_reg;
    assign job       = p_job_reg;

endmodule

// ===== design/ccfi_emitter.sv =====
// ccfi_emitter: holds one decoded item; sends its results through an output register one per cycle unless stalled
// depends on ccfi_pkg
module ccfi_emitter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  ccfi_pkg::ccfi_job_t  job,
    output logic                 job_ready,
    input  ccfi_pkg::ccfi_geom_t geom,
    output logic                 result_valid,
    input  logic                 result_ready,
    output ccfi_pkg::ccfi_out_t  result
);

    localparam int W  = ccfi_pkg::IDX_W;
    localparam int KW = ccfi_pkg::K_W;

    logic                busy_reg, busy_next;
    logic [KW-1:0]       k_reg, k_next;
    ccfi_pkg::ccfi_job_t job_reg;
    logic                res_valid_reg, res_valid_next;
    ccfi_pkg::ccfi_out_t res_reg, res_next;

    logic                slot, emit, take, last;
    logic [KW-1:0]       count;
    ccfi_pkg::ccfi_out_t cur;

    logic [1:0]          axis;
    logic [W-1:0]        step;
    logic [5:0]          off;
    logic [W-1:0]        oy_term, oz_term;
    logic [2:0]          even, minus;
    logic [1:0]          rank [3];
    logic [2:0]          kc;
    logic                outside;
    logic [W-1:0]        sub;

    always_comb
    begin
        if (job_reg.err)
            count = KW'(1);
        else
        begin
            case (job_reg.op)
                ccfi_pkg::OP_FACES:
                    count = (job_reg.dim == 2'd0) ? KW'(1) : KW'({job_reg.dim, 1'b0});
                ccfi_pkg::OP_CLOSURE:
                    count = ccfi_pkg::CLOSURE_COUNT;
                ccfi_pkg::OP_INCIDENT:
                    count = KW'(4'd1 << (2'd3 - job_reg.dim));
                default:
                    count = KW'(1);
            endcase
        end
    end

    assign last = k_reg == count - KW'(1);

    // per-result index arithmetic
    always_comb
    begin
        kc = k_reg[2:0];
        case (k_reg[2:1])
            2'd0:    axis = job_reg.odd[0] ? 2'd0 : (job_reg.odd[1] ? 2'd1 : 2'd2);
            2'd1:    axis = (job_reg.odd[0] && job_reg.odd[1]) ? 2'd1 : 2'd2;
            default: axis = 2'd2;
        endcase
        case (axis)
            2'd0:    step = W'(1);
            2'd1:    step = W'(geom.g0);
            default: step = W'(geom.g01);
        endcase

        off     = ccfi_pkg::closure_off(k_reg);
        oy_term = (off[3] ? W'({geom.g0, 1'b0}) : W'(0)) + (off[2] ? W'(geom.g0) : W'(0));
        oz_term = (off[1] ? W'({geom.g01, 1'b0}) : W'(0)) + (off[0] ? W'(geom.g01) : W'(0));

        even    = ~job_reg.odd;
        rank[0] = 2'd0;
        rank[1] = {1'b0, even[0]};
        rank[2] = 2'({1'b0, even[0]} + {1'b0, even[1]});
        outside = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            minus[i] = even[i] && kc[rank[i]];
            outside  = outside | (minus[i] ? job_reg.out_second[i] : job_reg.out_first[i]);
        end
        sub = (minus[0] ? W'(1) : W'(0)) + (minus[1] ? W'(geom.s0) : W'(0))
            + (minus[2] ? W'(geom.s01) : W'(0));

        cur.is_last = last;
        if (job_reg.err)
        begin
            cur.result_index   = job_reg.item;
            cur.cell_dimension = 2'd0;
            cur.kind           = ccfi_pkg::KIND_RANGE;
        end
        else
        begin
            case (job_reg.op)
                ccfi_pkg::OP_FACES:
                begin
                    if (job_reg.dim == 2'd0)
                    begin
                        cur.result_index   = job_reg.item;
                        cur.cell_dimension = 2'd0;
                        cur.kind           = ccfi_pkg::KIND_NO_FACES;
                    end
                    else
                    begin
                        cur.result_index   = k_reg[0] ? job_reg.item + step
                                                      : job_reg.item - step;
                        cur.cell_dimension = job_reg.dim - 2'd1;
                        cur.kind           = ccfi_pkg::KIND_VALID;
                    end
                end
                ccfi_pkg::OP_CLOSURE:
                begin
                    cur.result_index   = job_reg.base + W'(off[5:4]) + oy_term + oz_term;
                    cur.cell_dimension = 2'({1'b0, off[4]} + {1'b0, off[2]} + {1'b0, off[0]});
                    cur.kind           = ccfi_pkg::KIND_VALID;
                end
                ccfi_pkg::OP_INCIDENT:
                begin
                    cur.cell_dimension = 2'd3;
                    if (outside)
                    begin
                        cur.result_index = '0;
                        cur.kind         = ccfi_pkg::KIND_OUTSIDE;
                    end
                    else
                    begin
                        cur.result_index = job_reg.base - sub;
                        cur.kind         = ccfi_pkg::KIND_VALID;
                    end
                end
                default:
                begin
                    cur.result_index   = job_reg.item;
                    cur.cell_dimension = 2'd0;
                    cur.kind           = ccfi_pkg::KIND_RANGE;
                end
            endcase
        end
    end

    // sequencing
    always_comb
    begin
        slot      = !res_valid_reg || result_ready;
        emit      = busy_reg && slot;
        job_ready = !busy_reg || (emit && last);
        take      = job_valid && job_ready;

        if (take)
            busy_next = 1'b1;
        else if (emit && last)
            busy_next = 1'b0;
        else
            busy_next = busy_reg;

        if (take)
            k_next = '0;
        else if (emit)
            k_next = k_reg + KW'(1);
        else
            k_next = k_reg;

        if (emit)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;

        res_next = emit ? cur : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            job_reg <= job;
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== design/cubical_complex_face_indexer.sv =====
// items pass both dividers, the coord stages, the emitter job and result registers
// throughput: one result per cycle unless result_ready stalls; an item has 1 to 27
// results (27 for a voxel closure), all through the single result register
// the two coordinate divisions run as 14-stage pipelines, two quotient bits per stage
// reset: size registers return to 1, pipeline and output register empty
module cubical_complex_face_indexer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  ccfi_pkg::ccfi_in_t          item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output ccfi_pkg::ccfi_out_t         result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [ccfi_pkg::SIZE_W-1:0] cfg_data
);

    ccfi_pkg::ccfi_geom_t        geom;

    // whole pipeline moves together; it stalls only when the emitter holds
    // an item and the last stage has one waiting
    logic                        en;

    logic                        d1_valid;
    logic [ccfi_pkg::IDX_W-1:0]  d1_quot;
    logic [ccfi_pkg::GRID_W-1:0] d1_rem;
    ccfi_pkg::ccfi_side_t        d1_side;
    ccfi_pkg::ccfi_side_t        side_in, side_mid;
    logic [ccfi_pkg::GRID_W-1:0] div1_d, div2_d;

    logic                        d2_valid;
    logic [ccfi_pkg::IDX_W-1:0]  d2_quot;
    logic [ccfi_pkg::GRID_W-1:0] d2_rem;
    ccfi_pkg::ccfi_side_t        d2_side;

    logic                        job_valid, job_ready;
    ccfi_pkg::ccfi_job_t         job;

    assign cfg_ready  = 1'b1;
    assign en         = !job_valid || job_ready;
    assign item_ready = en;

    ccfi_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // first split: x coordinate and the remaining yz index
    // a voxel index divides by the voxel size s0, a cell index by the grid width g0
    assign div1_d  = (item.opcode == ccfi_pkg::OP_CLOSURE) ? {1'b0, geom.s0} : geom.g0;
    assign side_in = '{op: item.opcode, item: item.item_index, c0: '0};

    ccfi_divider u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item_valid),
        .dividend  (item.item_index),
        .divisor   (div1_d),
        .in_side   (side_in),
        .out_valid (d1_valid),
        .quotient  (d1_quot),
        .remainder (d1_rem),
        .out_side  (d1_side)
    );

    // second split: y is the remainder, z the quotient
    assign div2_d   = (d1_side.op == ccfi_pkg::OP_CLOSURE) ? {1'b0, geom.s1} : geom.g1;
    assign side_mid = '{op: d1_side.op, item: d1_side.item, c0: d1_rem};

    ccfi_divider u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d1_valid),
        .dividend  (d1_quot),
        .divisor   (div2_d),
        .in_side   (side_mid),
        .out_valid (d2_valid),
        .quotient  (d2_quot),
        .remainder (d2_rem),
        .out_side  (d2_side)
    );

    // range check, parity flags and base index of the closure or voxel neighborhood
    ccfi_coord u_coord (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d2_valid),
        .q2        (d2_quot),
        .r2        (d2_rem),
        .side      (d2_side),
        .geom      (geom),
        .job_valid (job_valid),
        .job       (job)
    );

    // result sequencer with the output register acting as skid stage
    ccfi_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .job_ready    (job_ready),
        .geom         (geom),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
